// ----- rtl/xcfp_pkg.sv -----
// shared types and constants for the xor checked frame parser
package xcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int NODE_W    = 16;
    localparam int PHASE_W   = 4;
    localparam int CFG_IDX_W = 2;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_IDLE    = 4'd0;
    localparam logic [PHASE_W-1:0] PH_LEN     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_NODE_HI = 4'd2;
    localparam logic [PHASE_W-1:0] PH_NODE_LO = 4'd3;
    localparam logic [PHASE_W-1:0] PH_EP      = 4'd4;
    localparam logic [PHASE_W-1:0] PH_CMD     = 4'd5;
    localparam logic [PHASE_W-1:0] PH_TYPE    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_PLEN    = 4'd7;
    localparam logic [PHASE_W-1:0] PH_PAYLOAD = 4'd8;
    localparam logic [PHASE_W-1:0] PH_SEQ     = 4'd9;
    localparam logic [PHASE_W-1:0] PH_CHECK   = 4'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_SEED = 2'd1;

    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hB1;
    localparam logic [BYTE_W-1:0] CHECK_SEED_RST = 8'h00;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_length;
        logic [NODE_W-1:0] node_id;
        logic [BYTE_W-1:0] endpoint;
        logic [BYTE_W-1:0] command_id;
        logic [BYTE_W-1:0] command_type;
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] sequence_res;
        logic              frame_ok;
        logic              last;
    } t_result;

endpackage

// ----- rtl/xcfp_rx_if.sv -----
// receive byte channel
interface xcfp_rx_if import xcfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/xcfp_res_if.sv -----
// result channel
interface xcfp_res_if import xcfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_index;
    logic [BYTE_W-1:0] frame_length;
    logic [NODE_W-1:0] node_id;
    logic [BYTE_W-1:0] endpoint;
    logic [BYTE_W-1:0] command_id;
    logic [BYTE_W-1:0] command_type;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] sequence_res;
    logic              frame_ok;
    logic              last;

    modport source (
        output valid, output result_kind, output payload_byte, output payload_index,
        output frame_length, output node_id, output endpoint, output command_id,
        output command_type, output payload_length, output sequence_res,
        output frame_ok, output last, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input payload_index,
        input frame_length, input node_id, input endpoint, input command_id,
        input command_type, input payload_length, input sequence_res,
        input frame_ok, input last, output ready
    );
endinterface

// ----- rtl/xcfp_parser.sv -----
// frame state machine, header capture, running xor and config registers
module xcfp_parser import xcfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg_wr           i_cfg,
    input  logic              i_acc,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_push,
    output t_result           o_result
);

    logic [BYTE_W-1:0]  r_start_byte, r_check_seed;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [BYTE_W-1:0]  r_length, r_endpoint, r_command, r_type, r_plen;
    logic [NODE_W-1:0]  r_node;
    logic [BYTE_W-1:0]  r_seen, r_sequence, r_accum;
    logic [BYTE_W-1:0]  n_seen, n_accum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_BYTE_RST;
            r_check_seed <= CHECK_SEED_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                CFG_START_BYTE: r_start_byte <= i_cfg.data;
                CFG_CHECK_SEED: r_check_seed <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_accum  = r_accum ^ i_byte;
        n_seen   = r_seen + 8'd1;
        o_push   = 1'b0;
        o_result = '0;
        unique case (r_phase)
            PH_IDLE: begin
                n_accum = r_check_seed;
                if (i_byte == r_start_byte) n_phase = PH_LEN;
            end
            PH_LEN: begin
                // length byte stays out of the check
                n_accum = r_accum;
                n_phase = PH_NODE_HI;
            end
            PH_NODE_HI: n_phase = PH_NODE_LO;
            PH_NODE_LO: n_phase = PH_EP;
            PH_EP:      n_phase = PH_CMD;
            PH_CMD:     n_phase = PH_TYPE;
            PH_TYPE:    n_phase = PH_PLEN;
            PH_PLEN: begin
                n_phase = (i_byte == '0) ? PH_SEQ : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                o_push                 = i_acc;
                o_result.result_kind   = KIND_PAYLOAD;
                o_result.payload_byte  = i_byte;
                o_result.payload_index = r_seen;
                if (n_seen == r_plen) n_phase = PH_SEQ;
            end
            PH_SEQ:     n_phase = PH_CHECK;
            PH_CHECK: begin
                o_push                  = i_acc;
                o_result.result_kind    = KIND_SUMMARY;
                o_result.frame_length   = r_length;
                o_result.node_id        = r_node;
                o_result.endpoint       = r_endpoint;
                o_result.command_id     = r_command;
                o_result.command_type   = r_type;
                o_result.payload_length = r_plen;
                o_result.sequence_res   = r_sequence;
                o_result.frame_ok       = (r_accum == i_byte);
                o_result.last           = 1'b1;
                n_phase                 = PH_IDLE;
            end
            default:    n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (i_acc) begin
            r_phase <= n_phase;
        end
    end

    // captured fields, only touched in their own phase
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_accum <= n_accum;
            case (r_phase)
                PH_LEN:     r_length <= i_byte;
                PH_NODE_HI: r_node <= {i_byte, 8'h00};
                PH_NODE_LO: r_node <= {r_node[NODE_W-1:BYTE_W], i_byte};
                PH_EP:      r_endpoint <= i_byte;
                PH_CMD:     r_command <= i_byte;
                PH_TYPE:    r_type <= i_byte;
                PH_PLEN: begin
                    r_plen <= i_byte;
                    r_seen <= '0;
                end
                PH_PAYLOAD: r_seen <= n_seen;
                PH_SEQ:     r_sequence <= i_byte;
                default: ;
            endcase
        end
    end

    a_push_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_phase == PH_PAYLOAD || r_phase == PH_CHECK))
        else $error("result pushed outside payload or check phase");

    a_check_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_phase == PH_CHECK) |=> (r_phase == PH_IDLE))
        else $error("parser did not return to idle after check byte");

    a_payload_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_seen != r_plen))
        else $error("payload count overran payload length");

    a_empty_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && r_phase == PH_PLEN && i_byte == '0) |=> (r_phase == PH_SEQ))
        else $error("empty payload did not skip to sequence byte");

endmodule

// ----- rtl/xcfp_out_stage.sv -----
// result register with a skid entry so input keeps flowing under stall until the skid fills
module xcfp_out_stage import xcfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_out_ready,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_result o_result
);

    logic    r_out_v, r_skid_v;
    t_result r_out, r_skid;
    logic    pop;

    assign pop         = r_out_v && i_out_ready;
    assign o_in_ready  = !r_skid_v;
    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || pop) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || pop) begin
            if (r_skid_v) r_out <= r_skid;
            else if (i_push) r_out <= i_result;
        end else if (i_push) begin
            r_skid <= i_result;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held while result register empty");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_push)
        else $error("request pushed into full output stage");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && pop) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved into result register");

endmodule

// ----- rtl/xor_checked_frame_parser_top.sv -----
// top level of the xor checked frame parser
//
//  channel   dir  handshake      payload
//  i_rx      in   valid/ready    rx_byte
//  o_res     out  valid/ready    result fields, last on frame summary
//  i_cfg_*   in   write enable   index 0 start byte, 1 check seed
//
//  one request per cycle while i_rx.ready is high; the result a byte causes is registered as that byte is taken
//  the state machine and xor update in the cycle a byte is taken
//  reset: start byte 0xb1, seed 0, parser hunting for the start byte
//  a stalled output fills a one-entry skid register, then i_rx.ready drops
module xor_checked_frame_parser_top import xcfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    xcfp_rx_if.sink              i_rx,
    xcfp_res_if.source           o_res
);

    t_cfg_wr cfg;
    t_result parsed, held;
    logic    acc, push, in_ready;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign i_rx.ready = in_ready;
    assign acc        = i_rx.valid && in_ready;

    xcfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_acc    (acc),
        .i_byte   (i_rx.rx_byte),
        .o_push   (push),
        .o_result (parsed)
    );

    xcfp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (parsed),
        .i_out_ready (o_res.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (o_res.valid),
        .o_result    (held)
    );

    assign o_res.result_kind    = held.result_kind;
    assign o_res.payload_byte   = held.payload_byte;
    assign o_res.payload_index  = held.payload_index;
    assign o_res.frame_length   = held.frame_length;
    assign o_res.node_id        = held.node_id;
    assign o_res.endpoint       = held.endpoint;
    assign o_res.command_id     = held.command_id;
    assign o_res.command_type   = held.command_type;
    assign o_res.payload_length = held.payload_length;
    assign o_res.sequence_res   = held.sequence_res;
    assign o_res.frame_ok       = held.frame_ok;
    assign o_res.last           = held.last;

endmodule

// ----- tb/sv/xcfp_frame_checker.sv -----
// scoreboard for the xor checked frame parser: tracks the parse and checks every result
`timescale 1ns / 100ps
module xcfp_frame_checker import xcfp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    xcfp_rx_if                   i_rx,
    xcfp_res_if                  i_res,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int MAX_REPORTS = 60;

    logic [BYTE_W-1:0]  hunt_byte;
    logic [BYTE_W-1:0]  seed_byte;

    logic [PHASE_W-1:0] parse_phase;
    logic [BYTE_W-1:0]  frame_len_q;
    logic [NODE_W-1:0]  node_q;
    logic [BYTE_W-1:0]  endpoint_q;
    logic [BYTE_W-1:0]  command_q;
    logic [BYTE_W-1:0]  cmd_type_q;
    logic [BYTE_W-1:0]  payload_len_q;
    logic [BYTE_W-1:0]  payload_pos;
    logic [BYTE_W-1:0]  sequence_q;
    logic [BYTE_W-1:0]  running_xor;

    t_result awaited_results[$];
    t_result want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task report_mismatch(input string msg);
        o_errors++;
        if (o_errors <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string name, input logic [NODE_W-1:0] got,
                               input logic [NODE_W-1:0] exp_val);
        if (got !== exp_val) begin
            report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, exp_val));
        end
    endtask

    // one received byte through the frame state machine
    function void advance_parser(input logic [BYTE_W-1:0] b);
        t_result r;
        r = '0;
        case (parse_phase)
            PH_IDLE: begin
                if (b == hunt_byte) begin
                    running_xor = seed_byte;
                    parse_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                frame_len_q = b;
                parse_phase = PH_NODE_HI;
            end
            PH_NODE_HI: begin
                node_q = {b, 8'h00};
                running_xor ^= b;
                parse_phase = PH_NODE_LO;
            end
            PH_NODE_LO: begin
                node_q[BYTE_W-1:0] = b;
                running_xor ^= b;
                parse_phase = PH_EP;
            end
            PH_EP: begin
                endpoint_q = b;
                running_xor ^= b;
                parse_phase = PH_CMD;
            end
            PH_CMD: begin
                command_q = b;
                running_xor ^= b;
                parse_phase = PH_TYPE;
            end
            PH_TYPE: begin
                cmd_type_q = b;
                running_xor ^= b;
                parse_phase = PH_PLEN;
            end
            PH_PLEN: begin
                payload_len_q = b;
                payload_pos = '0;
                running_xor ^= b;
                parse_phase = (b == '0) ? PH_SEQ : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                running_xor ^= b;
                r.result_kind   = KIND_PAYLOAD;
                r.payload_byte  = b;
                r.payload_index = payload_pos;
                awaited_results.push_back(r);
                payload_pos = payload_pos + 1'b1;
                if (payload_pos == payload_len_q) begin
                    parse_phase = PH_SEQ;
                end
            end
            PH_SEQ: begin
                sequence_q = b;
                running_xor ^= b;
                parse_phase = PH_CHECK;
            end
            PH_CHECK: begin
                r.result_kind    = KIND_SUMMARY;
                r.frame_length   = frame_len_q;
                r.node_id        = node_q;
                r.endpoint       = endpoint_q;
                r.command_id     = command_q;
                r.command_type   = cmd_type_q;
                r.payload_length = payload_len_q;
                r.sequence_res   = sequence_q;
                r.frame_ok       = (running_xor == b);
                r.last           = 1'b1;
                awaited_results.push_back(r);
                parse_phase = PH_IDLE;
            end
            default: begin
                parse_phase = PH_IDLE;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_results.delete();
            hunt_byte     = START_BYTE_RST;
            seed_byte     = CHECK_SEED_RST;
            parse_phase   = PH_IDLE;
            frame_len_q   = '0;
            node_q        = '0;
            endpoint_q    = '0;
            command_q     = '0;
            cmd_type_q    = '0;
            payload_len_q = '0;
            payload_pos   = '0;
            sequence_q    = '0;
            running_xor   = '0;
        end else begin
            if (i_rx.valid && i_rx.ready) begin
                advance_parser(i_rx.rx_byte);
            end
            if (i_res.valid && i_res.ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = awaited_results.pop_front();
                    check_field("result_kind", i_res.result_kind, want.result_kind);
                    check_field("payload_byte", i_res.payload_byte, want.payload_byte);
                    check_field("payload_index", i_res.payload_index, want.payload_index);
                    check_field("frame_length", i_res.frame_length, want.frame_length);
                    check_field("node_id", i_res.node_id, want.node_id);
                    check_field("endpoint", i_res.endpoint, want.endpoint);
                    check_field("command_id", i_res.command_id, want.command_id);
                    check_field("command_type", i_res.command_type, want.command_type);
                    check_field("payload_length", i_res.payload_length, want.payload_length);
                    check_field("sequence_res", i_res.sequence_res, want.sequence_res);
                    check_field("frame_ok", i_res.frame_ok, want.frame_ok);
                    check_field("last", i_res.last, want.last);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_START_BYTE: hunt_byte = i_cfg_data;
                    CFG_CHECK_SEED: seed_byte = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

// ----- tb/sv/xor_checked_frame_parser_top_tb.sv -----
// testbench top: frame stimulus, random flow control and final verdict
`timescale 1ns / 100ps
module xor_checked_frame_parser_top_tb;
    import xcfp_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RANDOM_ITEMS  = 650;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_GAP       = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef logic [BYTE_W-1:0] t_bytes[$];

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [BYTE_W-1:0]    i_cfg_data;

    xcfp_rx_if  rx_ch ();
    xcfp_res_if res_ch ();

    int error_count;
    int pending_count;
    int cycle_count = 0;
    int bytes_sent = 0;

    logic [BYTE_W-1:0] cur_start = START_BYTE_RST;
    logic [BYTE_W-1:0] cur_seed = CHECK_SEED_RST;
    bit send_quiet = 1'b0;
    bit recv_quiet = 1'b0;

    xor_checked_frame_parser_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    xcfp_frame_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .i_res      (res_ch),
        .o_errors   (error_count),
        .o_pending  (pending_count)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("xor_checked_frame_parser_top_tb: errors");
            $finish;
        end
    end

    function automatic int draw_gap(input bit quiet);
        if (quiet || $urandom_range(0, 1) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic t_bytes random_payload(input int n);
        t_bytes q;
        repeat (n) q.push_back(BYTE_W'($urandom));
        return q;
    endfunction

    // one byte request, with a random hold-off ahead of it
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if ($urandom_range(0, 19) == 0) begin
            send_quiet = !send_quiet;
        end
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= BYTE_W'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_ch.valid && rx_ch.ready));
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_START_BYTE: cur_start = data;
            CFG_CHECK_SEED: cur_seed = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // drop valid and let every expected result drain out
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [NODE_W-1:0] node, input logic [BYTE_W-1:0] len,
                              input logic [BYTE_W-1:0] ep, input logic [BYTE_W-1:0] cmd,
                              input logic [BYTE_W-1:0] cmd_type, input logic [BYTE_W-1:0] seq_b,
                              input t_bytes body, input bit corrupt);
        logic [BYTE_W-1:0] plen;
        logic [BYTE_W-1:0] xsum;
        plen = BYTE_W'(body.size());
        xsum = cur_seed ^ node[15:8] ^ node[7:0] ^ ep ^ cmd ^ cmd_type ^ plen ^ seq_b;
        foreach (body[i]) xsum ^= body[i];
        if (corrupt) begin
            xsum ^= BYTE_W'(1) << $urandom_range(0, BYTE_W - 1);
        end
        send_byte(cur_start);
        send_byte(len);
        send_byte(node[15:8]);
        send_byte(node[7:0]);
        send_byte(ep);
        send_byte(cmd);
        send_byte(cmd_type);
        send_byte(plen);
        foreach (body[i]) send_byte(body[i]);
        send_byte(seq_b);
        send_byte(xsum);
    endtask

    task automatic send_random_frame(input bit corrupt, input int plen);
        send_frame(NODE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                   BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                   random_payload(plen), corrupt);
    endtask

    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        if (pick < 75) begin
            send_random_frame(1'b0, n);
        end else if (pick < 87) begin
            send_random_frame(1'b1, n);
        end else if (pick < 97) begin
            // line noise between frames
            n = $urandom_range(1, 4);
            repeat (n) send_byte(BYTE_W'($urandom));
        end else begin
            // frame cut short; the parser keeps eating what follows
            send_byte(cur_start);
            n = $urandom_range(1, 8);
            repeat (n) send_byte(BYTE_W'($urandom));
        end
    endtask

    // result side: random stall before taking each result
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                recv_quiet = !recv_quiet;
            end
            stall = draw_gap(recv_quiet);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
            @(negedge i_clk);
        end
    end

    initial begin
        t_bytes body;
        logic [BYTE_W-1:0] old_seed;
        logic [BYTE_W-1:0] mid_check;
        int base;

        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START_BYTE;
        i_cfg_data    = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: junk ahead of the start byte, all-zero frame with empty payload
        send_byte(8'h00);
        body.delete();
        send_frame(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, body, 1'b0);
        // all-ones header, start byte inside the payload, bad check byte
        body = '{cur_start, 8'hFF};
        send_frame(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, body, 1'b1);

        base = bytes_sent;
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            case (p)
                0: begin
                    write_reg(CFG_START_BYTE, 8'h00);
                    write_reg(CFG_CHECK_SEED, 8'hFF);
                    write_reg(CFG_UNMAPPED, 8'h5A);
                end
                1: begin
                    write_reg(CFG_START_BYTE, 8'hFF);
                    write_reg(CFG_CHECK_SEED, 8'h00);
                end
                default: begin
                    write_reg(CFG_START_BYTE, BYTE_W'($urandom));
                    write_reg(CFG_CHECK_SEED, BYTE_W'($urandom));
                end
            endcase

            if (p == 2) begin
                // seed changes mid-frame; the frame keeps the seed it started with
                old_seed = cur_seed;
                send_byte(cur_start);
                send_byte(8'h0C);
                send_byte(8'h12);
                wait_idle();
                write_reg(CFG_CHECK_SEED, ~old_seed);
                mid_check = old_seed ^ 8'h12 ^ 8'h34 ^ 8'h56 ^ 8'h78 ^ 8'h9A ^ 8'h00 ^ 8'hBC;
                send_byte(8'h34);
                send_byte(8'h56);
                send_byte(8'h78);
                send_byte(8'h9A);
                send_byte(8'h00);
                send_byte(8'hBC);
                send_byte(mid_check);
            end

            if (p == 3) begin
                send_random_frame(1'b0, 255);
            end

            while (bytes_sent - base < (p + 1) * RANDOM_ITEMS / NUM_PHASES) begin
                random_burst();
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("xor_checked_frame_parser_top_tb: clean");
        end else begin
            $display("xor_checked_frame_parser_top_tb: errors");
        end
        $finish;
    end

endmodule
